// ----- hw/rtl/stff_pkg.sv -----
// Shared types and constants of the slot table with first-free allocation.
package stff_pkg;

	localparam int KIND_W  = 2;
	localparam int COUNT_W = 5;
	localparam int SLOT_W  = 4;
	localparam int LKEY_W  = 16;

	localparam logic [KIND_W-1:0] KIND_PUT    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_LIST   = 2'd2;

	typedef enum logic [2:0] {
		EMIT_NONE,
		EMIT_FAIL,
		EMIT_PUT,
		EMIT_REM,
		EMIT_LIST
	} emit_t;

	typedef struct packed {
		logic  ld;
		logic  idx_clr;
		logic  idx_inc;
		logic  scan_rd;
		logic  set_put;
		emit_t emit;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic almost_full;
		logic empty;
		logic idx_used;
		logic idx_last;
		logic hit_s1;
		logic miss_end_s1;
		logic used_s1;
		logic list_final;
	} sts_t;

endpackage

// ----- hw/rtl/slot_table_first_free.sv -----
// Slot table with first-free allocation: top level.
//
// Requests enter on start/kind/key and are taken when start is high and busy is
// low. kind selects put, remove or list; key is ignored for list. Results leave on
// ok/count/slot/listed_key/last, each valid for exactly one cycle while strobe is
// high; last marks the final result of a request. The receiver cannot stall.
//
// Request handling by kind:
//   put: one result in the cycle after the request. If the table is not full
//     afterwards, busy then stays high while the occupancy bits are walked from
//     slot 0 to the lowest free slot, one slot per cycle.
//   remove: the keys are read from the key RAM one slot per cycle; the registered
//     read data is compared with the key, and a match or a miss at the last slot
//     is registered as the result.
//   list: the same one-slot-per-cycle RAM scan; one result per occupied slot.
//   a put when full, a remove or list when empty, kind 3: one result the next cycle.
// The single read port of the key RAM sets the scan rate of one slot per cycle.
// Reset empties the table at once; no clearing pass is needed.
module slot_table_first_free #(
	parameter int SLOTS    = 16,
	parameter int KEY_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [stff_pkg::KIND_W-1:0]  kind,
	input  logic [KEY_BITS-1:0]          key,
	output logic                         strobe,
	output logic                         ok,
	output logic [stff_pkg::COUNT_W-1:0] count,
	output logic [stff_pkg::SLOT_W-1:0]  slot,
	output logic [stff_pkg::LKEY_W-1:0]  listed_key,
	output logic                         last
);

	stff_pkg::cmd_t cmd;
	stff_pkg::sts_t sts;

	stff_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	stff_dp #(
		.SLOTS    (SLOTS),
		.KEY_BITS (KEY_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.key        (key),
		.cmd        (cmd),
		.sts        (sts),
		.strobe     (strobe),
		.ok         (ok),
		.count      (count),
		.slot       (slot),
		.listed_key (listed_key),
		.last       (last)
	);

	// an item still emitting results keeps the block busy
	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("non-final result while not busy");

	// every accepted item either answers at once or is being worked on
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> strobe || busy)
		else $error("accepted item dropped");

	// a failed request gives a single result
	a_fail_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !ok |-> last)
		else $error("failed result not final");

	// a put is only written while the table has room
	a_put_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit == stff_pkg::EMIT_PUT |-> !sts.full)
		else $error("put on full table");

endmodule

// ----- hw/rtl/stff_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module stff_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

// ----- hw/rtl/stff_ctrl.sv -----
// Controller state machine: decodes requests and sequences the slot scans.
module stff_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [stff_pkg::KIND_W-1:0] kind,
	input  stff_pkg::sts_t              sts,
	output stff_pkg::cmd_t              cmd,
	output logic                        busy
);

	typedef enum logic [1:0] {
		IDLE,
		PUT_SCAN,
		REM_SCAN,
		LIST_SCAN
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			IDLE: begin
				if (start) begin
					cmd.ld = 1'b1;
					unique case (kind)
						stff_pkg::KIND_PUT: begin
							if (sts.full) begin
								cmd.emit = stff_pkg::EMIT_FAIL;
							end else begin
								cmd.emit = stff_pkg::EMIT_PUT;
								// look for the next free slot unless this put fills the table
								if (!sts.almost_full) begin
									cmd.idx_clr = 1'b1;
									state_d     = PUT_SCAN;
								end
							end
						end
						stff_pkg::KIND_REMOVE: begin
							if (sts.empty) begin
								cmd.emit = stff_pkg::EMIT_FAIL;
							end else begin
								cmd.idx_clr = 1'b1;
								state_d     = REM_SCAN;
							end
						end
						stff_pkg::KIND_LIST: begin
							if (sts.empty) begin
								cmd.emit = stff_pkg::EMIT_FAIL;
							end else begin
								cmd.idx_clr = 1'b1;
								state_d     = LIST_SCAN;
							end
						end
						default: begin
							cmd.emit = stff_pkg::EMIT_FAIL;
						end
					endcase
				end
			end
			PUT_SCAN: begin
				if (!sts.idx_used) begin
					cmd.set_put = 1'b1;
					state_d     = IDLE;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			REM_SCAN: begin
				cmd.scan_rd = 1'b1;
				cmd.idx_inc = !sts.idx_last;
				if (sts.hit_s1) begin
					cmd.emit = stff_pkg::EMIT_REM;
					state_d  = IDLE;
				end else if (sts.miss_end_s1) begin
					cmd.emit = stff_pkg::EMIT_FAIL;
					state_d  = IDLE;
				end
			end
			LIST_SCAN: begin
				cmd.scan_rd = 1'b1;
				cmd.idx_inc = !sts.idx_last;
				if (sts.used_s1) begin
					cmd.emit = stff_pkg::EMIT_LIST;
					if (sts.list_final)
						state_d = IDLE;
				end
			end
			default: begin
				state_d = IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			busy    <= 1'b0;
		end else begin
			state_q <= state_d;
			busy    <= (state_d != IDLE);
		end
	end

endmodule

// ----- hw/rtl/stff_dp.sv -----
// Datapath: key store, occupancy bits, counters, scan pipeline and result registers.
module stff_dp #(
	parameter int SLOTS    = 16,
	parameter int KEY_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [KEY_BITS-1:0]          key,
	input  stff_pkg::cmd_t               cmd,
	output stff_pkg::sts_t               sts,
	output logic                         strobe,
	output logic                         ok,
	output logic [stff_pkg::COUNT_W-1:0] count,
	output logic [stff_pkg::SLOT_W-1:0]  slot,
	output logic [stff_pkg::LKEY_W-1:0]  listed_key,
	output logic                         last
);

	localparam int IW  = $clog2(SLOTS);
	localparam int CW  = $clog2(SLOTS + 1);
	localparam int OCW = stff_pkg::COUNT_W;
	localparam int OSW = stff_pkg::SLOT_W;
	localparam int OKW = stff_pkg::LKEY_W;

	logic [KEY_BITS-1:0] key_q;
	logic [SLOTS-1:0]    used_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       lcnt_q;
	logic [IW-1:0]       put_q;
	logic [IW-1:0]       idx_q;
	logic [IW-1:0]       idx_s1;
	logic                v_s1;
	logic [KEY_BITS-1:0] rdata;
	logic [CW-1:0]       cnt_inc;
	logic [CW-1:0]       cnt_dec;
	logic [CW-1:0]       lcnt_inc;

	stff_ram #(
		.WIDTH (KEY_BITS),
		.DEPTH (SLOTS)
	) u_keys (
		.clk   (clk),
		.we    (cmd.emit == stff_pkg::EMIT_PUT),
		.waddr (put_q),
		.wdata (key),
		.re    (cmd.scan_rd),
		.raddr (idx_q),
		.rdata (rdata)
	);

	assign cnt_inc  = cnt_q + CW'(1);
	assign cnt_dec  = cnt_q - CW'(1);
	assign lcnt_inc = lcnt_q + CW'(1);

	always_comb begin
		sts.full        = (cnt_q == CW'(SLOTS));
		sts.almost_full = (cnt_q == CW'(SLOTS - 1));
		sts.empty       = (cnt_q == '0);
		sts.idx_used    = used_q[idx_q];
		sts.idx_last    = (idx_q == IW'(SLOTS - 1));
		sts.used_s1     = v_s1 && used_q[idx_s1];
		sts.hit_s1      = sts.used_s1 && (rdata == key_q);
		sts.miss_end_s1 = v_s1 && (idx_s1 == IW'(SLOTS - 1)) && !sts.hit_s1;
		sts.list_final  = (lcnt_inc == cnt_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			cnt_q  <= '0;
			lcnt_q <= '0;
			put_q  <= '0;
			idx_q  <= '0;
			v_s1   <= 1'b0;
			strobe <= 1'b0;
		end else begin
			v_s1   <= cmd.scan_rd;
			strobe <= (cmd.emit != stff_pkg::EMIT_NONE);
			if (cmd.idx_clr)
				idx_q <= '0;
			else if (cmd.idx_inc)
				idx_q <= idx_q + IW'(1);
			if (cmd.idx_clr)
				lcnt_q <= '0;
			else if (cmd.emit == stff_pkg::EMIT_LIST)
				lcnt_q <= lcnt_inc;
			if (cmd.set_put)
				put_q <= idx_q;
			case (cmd.emit)
				stff_pkg::EMIT_PUT: begin
					used_q[put_q] <= 1'b1;
					cnt_q         <= cnt_inc;
				end
				stff_pkg::EMIT_REM: begin
					// freed slot becomes the next put slot
					used_q[idx_s1] <= 1'b0;
					put_q          <= idx_s1;
					cnt_q          <= cnt_dec;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (cmd.ld)
			key_q <= key;
		case (cmd.emit)
			stff_pkg::EMIT_PUT: begin
				ok         <= 1'b1;
				count      <= OCW'(cnt_inc);
				slot       <= OSW'(put_q);
				listed_key <= '0;
				last       <= 1'b1;
			end
			stff_pkg::EMIT_REM: begin
				ok         <= 1'b1;
				count      <= OCW'(cnt_dec);
				slot       <= OSW'(idx_s1);
				listed_key <= '0;
				last       <= 1'b1;
			end
			stff_pkg::EMIT_LIST: begin
				ok         <= 1'b1;
				count      <= OCW'(cnt_q);
				slot       <= OSW'(idx_s1);
				listed_key <= OKW'(rdata);
				last       <= sts.list_final;
			end
			stff_pkg::EMIT_FAIL: begin
				ok         <= 1'b0;
				count      <= OCW'(cnt_q);
				slot       <= '0;
				listed_key <= '0;
				last       <= 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- verif/slot_table_first_free_tb.sv -----
// Testbench for the first-free slot table: random and directed requests against a predictor.
`timescale 1ns / 100ps

localparam int TABLE_SLOTS = 16;
localparam int KEY_W       = 16;

typedef struct packed {
	logic                         ok;
	logic [stff_pkg::COUNT_W-1:0] count;
	logic [stff_pkg::SLOT_W-1:0]  slot;
	logic [stff_pkg::LKEY_W-1:0]  listed_key;
	logic                         last;
} slot_reply_t;

class slot_table_tracker;
	bit [KEY_W-1:0] slot_key[TABLE_SLOTS];
	bit             slot_taken[TABLE_SLOTS];
	int unsigned    taken;
	int unsigned    next_put;
	slot_reply_t    pending[$];
	int unsigned    errors;
	int unsigned    replies_seen;

	function new();
		foreach (slot_taken[i]) begin
			slot_taken[i] = 1'b0;
			slot_key[i]   = '0;
		end
		taken        = 0;
		next_put     = 0;
		errors       = 0;
		replies_seen = 0;
	endfunction

	task report(string msg);
		errors++;
		$display("MISMATCH: %s", msg);
	endtask

	function void push_reply(bit ok, int unsigned at, bit [KEY_W-1:0] lkey, bit last);
		slot_reply_t r;
		r.ok         = ok;
		r.count      = taken[stff_pkg::COUNT_W-1:0];
		r.slot       = at[stff_pkg::SLOT_W-1:0];
		r.listed_key = lkey;
		r.last       = last;
		pending.push_back(r);
	endfunction

	// Work out the results of one accepted request and update the table copy.
	function void note_request(logic [stff_pkg::KIND_W-1:0] k, logic [KEY_W-1:0] kv);
		int unsigned at;
		bit          hit;
		int          listed;
		hit    = 1'b0;
		listed = 0;
		case (k)
			stff_pkg::KIND_PUT: begin
				if (taken >= TABLE_SLOTS) begin
					push_reply(1'b0, 0, '0, 1'b1);
				end else begin
					at               = next_put;
					slot_key[at]     = kv;
					slot_taken[at]   = 1'b1;
					taken++;
					if (taken < TABLE_SLOTS) begin
						for (int i = 0; i < TABLE_SLOTS; i++) begin
							if (!slot_taken[i] && !hit) begin
								next_put = i;
								hit      = 1'b1;
							end
						end
					end
					push_reply(1'b1, at, '0, 1'b1);
				end
			end
			stff_pkg::KIND_REMOVE: begin
				for (int i = 0; i < TABLE_SLOTS; i++) begin
					if (!hit && slot_taken[i] && slot_key[i] == kv) begin
						hit           = 1'b1;
						slot_taken[i] = 1'b0;
						next_put      = i;
						taken--;
						push_reply(1'b1, i, '0, 1'b1);
					end
				end
				if (!hit)
					push_reply(1'b0, 0, '0, 1'b1);
			end
			stff_pkg::KIND_LIST: begin
				for (int i = 0; i < TABLE_SLOTS; i++) begin
					if (slot_taken[i]) begin
						listed++;
						push_reply(1'b1, i, slot_key[i], listed == taken);
					end
				end
				if (listed == 0)
					push_reply(1'b0, 0, '0, 1'b1);
			end
			default: push_reply(1'b0, 0, '0, 1'b1);
		endcase
	endfunction

	task check_result(slot_reply_t got);
		slot_reply_t want;
		replies_seen++;
		if (pending.size() == 0) begin
			report($sformatf("result %0d with nothing outstanding: ok=%0d count=%0d slot=%0d key=%h last=%0d",
				replies_seen, got.ok, got.count, got.slot, got.listed_key, got.last));
			return;
		end
		want = pending.pop_front();
		if (got !== want)
			report($sformatf("result %0d: got ok=%0d count=%0d slot=%0d key=%h last=%0d, want ok=%0d count=%0d slot=%0d key=%h last=%0d",
				replies_seen, got.ok, got.count, got.slot, got.listed_key, got.last,
				want.ok, want.count, want.slot, want.listed_key, want.last));
	endtask

	function int unsigned outstanding();
		return pending.size();
	endfunction

	function bit [KEY_W-1:0] stored_key();
		int unsigned held[$];
		foreach (slot_taken[i])
			if (slot_taken[i])
				held.push_back(i);
		return slot_key[held[$urandom_range(0, held.size() - 1)]];
	endfunction
endclass

module slot_table_first_free_tb;

	localparam int RANDOM_ITEMS = 250;
	localparam int QUIET_FROM   = 200;

	// request code that the block does not use
	localparam logic [stff_pkg::KIND_W-1:0] KIND_BAD = 2'd3;

	logic                                 clk = 1'b0;
	logic                                 arst_n;
	logic                                 start;
	logic                                 busy;
	logic [stff_pkg::KIND_W-1:0]          kind;
	logic [KEY_W-1:0]                     key;
	logic                                 strobe;
	logic                                 ok;
	logic [stff_pkg::COUNT_W-1:0]         count;
	logic [stff_pkg::SLOT_W-1:0]          slot;
	logic [stff_pkg::LKEY_W-1:0]          listed_key;
	logic                                 last;

	slot_table_tracker    tracker;
	bit                   idle_on;
	bit [KEY_W-1:0]       key_pool[6];

	slot_table_first_free #(
		.SLOTS(TABLE_SLOTS),
		.KEY_BITS(KEY_W)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.key(key),
		.strobe(strobe),
		.ok(ok),
		.count(count),
		.slot(slot),
		.listed_key(listed_key),
		.last(last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		slot_reply_t got;
		if (arst_n === 1'b1 && strobe === 1'b1) begin
			got.ok         = ok;
			got.count      = count;
			got.slot       = slot;
			got.listed_key = listed_key;
			got.last       = last;
			tracker.check_result(got);
		end
	end

	function automatic int unsigned next_gap(int idx);
		if (idx >= QUIET_FROM || !idle_on)
			return 0;
		return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
	endfunction

	// Hold start high across back-to-back items; drop it only for an idle burst.
	task automatic issue(input logic [stff_pkg::KIND_W-1:0] k, input logic [KEY_W-1:0] kv,
			input int unsigned gap);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		kind  <= k;
		key   <= kv;
		do @(posedge clk); while (busy !== 1'b0);
		tracker.note_request(k, kv);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (tracker.outstanding() != 0);
	endtask

	initial begin
		#200000;
		$display("slot_table_first_free_tb NOT OK");
		$finish;
	end

	initial begin
		logic [stff_pkg::KIND_W-1:0] k;
		logic [KEY_W-1:0]            kv;
		int unsigned                 roll;
		bit                          filling;

		tracker = new();
		idle_on = 1'b1;
		filling = 1'b0;
		foreach (key_pool[i])
			key_pool[i] = KEY_W'($urandom);
		arst_n <= 1'b0;
		start  <= 1'b0;
		kind   <= stff_pkg::KIND_PUT;
		key    <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Empty table, then fill with extreme and duplicate keys up to full; then put, list and remove at full.
		issue(stff_pkg::KIND_LIST, 16'h1234, 0);
		issue(stff_pkg::KIND_REMOVE, 16'h1234, next_gap(0));
		issue(KIND_BAD, 16'hFFFF, next_gap(0));
		issue(stff_pkg::KIND_PUT, 16'h0000, next_gap(0));
		issue(stff_pkg::KIND_PUT, 16'hFFFF, next_gap(0));
		issue(stff_pkg::KIND_PUT, 16'hFFFF, next_gap(0));
		issue(stff_pkg::KIND_REMOVE, 16'hFFFF, next_gap(0));
		issue(stff_pkg::KIND_PUT, 16'hA5A5, next_gap(0));
		issue(stff_pkg::KIND_REMOVE, 16'h5A5A, next_gap(0));
		for (int i = 0; i < 13; i++)
			issue(stff_pkg::KIND_PUT, KEY_W'(16'h5A5A ^ (16'h1111 * i)), next_gap(0));
		issue(stff_pkg::KIND_PUT, 16'h7777, next_gap(0));
		issue(stff_pkg::KIND_LIST, 16'h0000, next_gap(0));
		issue(stff_pkg::KIND_REMOVE, 16'h0000, next_gap(0));
		issue(stff_pkg::KIND_PUT, 16'h8001, next_gap(0));
		issue(KIND_BAD, 16'h0000, next_gap(0));
		wait_drained();

		// Alternate between filling and draining phases with a small key pool.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 16 == 0)
				idle_on = ($urandom_range(0, 2) != 0);
			if (n % 40 == 0)
				filling = !filling;
			roll = $urandom_range(0, 99);
			if (roll < (filling ? 60 : 25))
				k = stff_pkg::KIND_PUT;
			else if (roll < 80)
				k = stff_pkg::KIND_REMOVE;
			else if (roll < 95)
				k = stff_pkg::KIND_LIST;
			else
				k = KIND_BAD;
			if (k == stff_pkg::KIND_REMOVE && tracker.taken != 0 && $urandom_range(0, 99) < 65)
				kv = tracker.stored_key();
			else if ($urandom_range(0, 1) == 0)
				kv = key_pool[$urandom_range(0, 5)];
			else
				kv = KEY_W'($urandom);
			if (n < QUIET_FROM && $urandom_range(0, 59) == 0)
				wait_drained();
			issue(k, kv, next_gap(n));
		end

		wait_drained();
		repeat (TABLE_SLOTS + 4) @(posedge clk);
		if (tracker.errors == 0 && tracker.outstanding() == 0)
			$display("slot_table_first_free_tb OK");
		else
			$display("slot_table_first_free_tb NOT OK");
		$finish;
	end

endmodule
